// ----- hw/rtl/sag_pkg.sv -----
// ----------------------------------------------------------------------------
// sag_pkg
// Shared types and constants for the sliding attack generator.
// ----------------------------------------------------------------------------
package sag_pkg;

	localparam int BOARD_SIDE    = 8;
	localparam int BOARD_SQUARES = BOARD_SIDE * BOARD_SIDE;
	localparam int SQ_W          = $clog2(BOARD_SQUARES);
	localparam int RANK_W        = $clog2(BOARD_SIDE);
	localparam int NUM_DIRS      = 4;
	localparam int RAY_STEPS     = BOARD_SIDE - 1;
	// one sign bit plus headroom for a coordinate that has stepped off the board
	localparam int COORD_W       = RANK_W + 2;

	typedef logic [BOARD_SQUARES-1:0] board_t;
	typedef logic [SQ_W-1:0]          square_t;
	typedef logic signed [1:0]        delta_t;

	typedef enum logic [2:0] {
		DIR_N  = 3'd0,
		DIR_E  = 3'd1,
		DIR_S  = 3'd2,
		DIR_W  = 3'd3,
		DIR_NE = 3'd4,
		DIR_SE = 3'd5,
		DIR_SW = 3'd6,
		DIR_NW = 3'd7
	} dir_t;

	typedef enum logic {
		PIECE_ROOK   = 1'b0,
		PIECE_BISHOP = 1'b1
	} piece_t;

	function automatic dir_t piece_dir(input piece_t kind, input logic [1:0] idx);
		dir_t d;
		if (kind == PIECE_BISHOP) begin
			case (idx)
				2'd0:    d = DIR_NE;
				2'd1:    d = DIR_SE;
				2'd2:    d = DIR_SW;
				default: d = DIR_NW;
			endcase
		end else begin
			case (idx)
				2'd0:    d = DIR_N;
				2'd1:    d = DIR_E;
				2'd2:    d = DIR_S;
				default: d = DIR_W;
			endcase
		end
		return d;
	endfunction

	function automatic delta_t dir_dr(input dir_t d);
		delta_t v;
		case (d)
			DIR_N, DIR_NE, DIR_NW: v = 2'sd1;
			DIR_S, DIR_SE, DIR_SW: v = -2'sd1;
			default:               v = 2'sd0;
		endcase
		return v;
	endfunction

	function automatic delta_t dir_df(input dir_t d);
		delta_t v;
		case (d)
			DIR_E, DIR_NE, DIR_SE: v = 2'sd1;
			DIR_W, DIR_SW, DIR_NW: v = -2'sd1;
			default:               v = 2'sd0;
		endcase
		return v;
	endfunction

endpackage

// ----- hw/rtl/sliding_attack_generator.sv -----
// ----------------------------------------------------------------------------
// sliding_attack_generator
// Rook and bishop attack sets from a square and an occupancy board.
// ----------------------------------------------------------------------------
// Request channel: req_valid/req_stall carry req_type (0 rook, 1 bishop),
// from_square and occupancy. A transfer happens on a rising edge with
// req_valid high and req_stall low.
// Result channel: rsp_valid/rsp_stall carry attack_set, the OR of the four
// rays cut after (and including) the first occupied square on each.
// The request lands in the input register; the four ray units work in
// parallel between it and the result register. Throughput is one request
// per cycle while req_stall is low; every request gives one result.
// When the receiver stalls, the result register holds and the input
// register still takes one more request; req_stall rises only when both
// registers are full and the result is stalled.
// Reset clears both valid flags; no request is pending afterward.
// ----------------------------------------------------------------------------
module sliding_attack_generator
	import sag_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic       req_type,
	input  logic [5:0] from_square,
	input  logic [63:0] occupancy,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [63:0] attack_set
);

	logic    valid_s1;
	piece_t  type_s1;
	square_t sq_s1;
	board_t  occ_s1;
	logic    valid_s2;
	board_t  attack_s2;
	logic    load_s2;
	logic    load_s1;
	board_t  ray [NUM_DIRS];
	board_t  attack_d;

	assign load_s2   = !valid_s2 || !rsp_stall;
	assign req_stall = valid_s1 && !load_s2;
	assign load_s1   = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || load_s2) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			type_s1 <= piece_t'(req_type);
			sq_s1   <= from_square;
			occ_s1  <= occupancy;
		end
	end

	for (genvar d = 0; d < NUM_DIRS; d++) begin : g_ray
		sag_ray u_ray (
			.dir (piece_dir(type_s1, 2'(d))),
			.sq  (sq_s1),
			.occ (occ_s1),
			.ray (ray[d])
		);
	end

	assign attack_d = ray[0] | ray[1] | ray[2] | ray[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			attack_s2 <= attack_d;
		end
	end

	assign rsp_valid  = valid_s2;
	assign attack_set = attack_s2;

endmodule

// ----- hw/rtl/sag_ray.sv -----
// ----------------------------------------------------------------------------
// sag_ray
// One ray from a square toward the board edge, cut after the first blocker.
// ----------------------------------------------------------------------------
module sag_ray
	import sag_pkg::*;
(
	input  dir_t    dir,
	input  square_t sq,
	input  board_t  occ,
	output board_t  ray
);

	delta_t dr;
	delta_t df;

	assign dr = dir_df(dir) == 2'sd0 ? dir_dr(dir) : dir_dr(dir);
	assign df = dir_df(dir);

	always_comb begin
		logic signed [COORD_W-1:0] r;
		logic signed [COORD_W-1:0] f;
		logic signed [COORD_W-1:0] dr_x;
		logic signed [COORD_W-1:0] df_x;
		logic                      stop;
		square_t                   idx;
		ray  = '0;
		dr_x = {{(COORD_W-2){dr[1]}}, dr};
		df_x = {{(COORD_W-2){df[1]}}, df};
		r    = {2'b00, sq[SQ_W-1:RANK_W]};
		f    = {2'b00, sq[RANK_W-1:0]};
		stop = (dr == 2'sd0) && (df == 2'sd0);
		for (int k = 0; k < RAY_STEPS; k++) begin
			r = r + dr_x;
			f = f + df_x;
			if (r[COORD_W-1:RANK_W] != '0 || f[COORD_W-1:RANK_W] != '0)
				stop = 1'b1;
			idx = {r[RANK_W-1:0], f[RANK_W-1:0]};
			if (!stop) begin
				ray[idx] = 1'b1;
				if (occ[idx])
					stop = 1'b1;
			end
		end
	end

endmodule
